[design/smpq_pkg.sv]
package smpq_pkg;

  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int DATA_W          = 32;
  localparam int STATUS_W        = 2;
  localparam int OCC_W           = 5;

  localparam logic FUNC_INSERT = 1'b0;
  localparam logic FUNC_DELETE = 1'b1;

  localparam logic [STATUS_W-1:0] ST_INSERTED  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_REMOVED   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd3;

  typedef logic signed [DATA_W-1:0] word_t;

  typedef struct packed {
    logic ins;
    logic del;
  } smpq_op_t;

endpackage

[design/smpq_if.sv]
interface smpq_in_if import smpq_pkg::*; ();
  logic  valid;
  logic  ready;
  logic  func;
  word_t in_value;
  word_t in_priority;

  modport source (output valid, func, in_value, in_priority, input ready);
  modport sink   (input valid, func, in_value, in_priority, output ready);
endinterface

interface smpq_out_if import smpq_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  word_t               out_value;
  word_t               out_priority;
  logic [OCC_W-1:0]    occupancy;

  modport source (output valid, status, out_value, out_priority, occupancy, input ready);
  modport sink   (input valid, status, out_value, out_priority, occupancy, output ready);
endinterface

[design/smpq_cell.sv]
module smpq_cell import smpq_pkg::*; (
  input  logic     clk,
  input  smpq_op_t op,
  input  logic     occupied,
  input  word_t    new_value,
  input  word_t    new_prio,
  input  logic     left_after,
  input  word_t    left_value,
  input  word_t    left_prio,
  input  word_t    right_value,
  input  word_t    right_prio,
  output word_t    value,
  output word_t    prio,
  output logic     after
);

  // new pair goes behind this entry when it is stored with equal or smaller priority
  assign after = occupied && (prio <= new_prio);

  always_ff @(posedge clk) begin
    if (op.ins && !after) begin
      if (left_after) begin
        value <= new_value;
        prio  <= new_prio;
      end else begin
        value <= left_value;
        prio  <= left_prio;
      end
    end else if (op.del) begin
      value <= right_value;
      prio  <= right_prio;
    end
  end

endmodule

[design/stable_min_priority_queue.sv]
// Bounded stable priority queue built as a row of QUEUE_DEPTH compare-and-shift
// cells, front at cell 0. Every cell compares its priority with the incoming one
// and either holds, takes the new pair or takes its neighbour's, so an insert or a
// delete completes whatever the fill level; one transfer is accepted per cycle
// while rsp is free; its result appears in the output register on the next cycle.
// Equal priorities leave in arrival order. Delete on empty reports underflow,
// insert on full is refused; out_value and out_priority are zero except on removal.
module stable_min_priority_queue import smpq_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  smpq_in_if.sink           req,
  smpq_out_if.source        rsp
);

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int EXT_W = (CNT_W > OCC_W) ? CNT_W : OCC_W;

  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic [EXT_W-1:0] count_ext;
  logic             accept;
  logic             full;
  logic             empty;
  smpq_op_t         op;

  word_t cell_value [QUEUE_DEPTH];
  word_t cell_prio  [QUEUE_DEPTH];
  logic  cell_after [QUEUE_DEPTH];

  assign accept    = req.valid && req.ready;
  assign req.ready = !rst && (!rsp.valid || rsp.ready);
  assign full      = (count == CNT_W'(QUEUE_DEPTH));
  assign empty     = (count == '0);
  assign op.ins    = accept && (req.func == FUNC_INSERT) && !full;
  assign op.del    = accept && (req.func == FUNC_DELETE) && !empty;

  always_comb begin
    count_next = count;
    if (op.ins) begin
      count_next = count + 1'b1;
    end else if (op.del) begin
      count_next = count - 1'b1;
    end
  end

  assign count_ext = EXT_W'(count_next);

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic  occ;
    logic  l_after;
    word_t l_value;
    word_t l_prio;
    word_t r_value;
    word_t r_prio;

    assign occ = (CNT_W'(i) < count);

    if (i == 0) begin : g_head
      assign l_after = 1'b1;
      assign l_value = req.in_value;
      assign l_prio  = req.in_priority;
    end else begin : g_body
      assign l_after = cell_after[i-1];
      assign l_value = cell_value[i-1];
      assign l_prio  = cell_prio[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_tail
      assign r_value = '0;
      assign r_prio  = '0;
    end else begin : g_mid
      assign r_value = cell_value[i+1];
      assign r_prio  = cell_prio[i+1];
    end

    smpq_cell u_cell (
      .clk         (clk),
      .op          (op),
      .occupied    (occ),
      .new_value   (req.in_value),
      .new_prio    (req.in_priority),
      .left_after  (l_after),
      .left_value  (l_value),
      .left_prio   (l_prio),
      .right_value (r_value),
      .right_prio  (r_prio),
      .value       (cell_value[i]),
      .prio        (cell_prio[i]),
      .after       (cell_after[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      rsp.valid <= 1'b0;
    end else begin
      count <= count_next;
      if (accept) begin
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rsp.occupancy    <= count_ext[OCC_W-1:0];
      rsp.out_value    <= '0;
      rsp.out_priority <= '0;
      if (req.func == FUNC_INSERT) begin
        rsp.status <= full ? ST_FULL : ST_INSERTED;
      end else if (empty) begin
        rsp.status <= ST_UNDERFLOW;
      end else begin
        rsp.status       <= ST_REMOVED;
        rsp.out_value    <= cell_value[0];
        rsp.out_priority <= cell_prio[0];
      end
    end
  end

endmodule
